@@ hdl/coe_hvp_pkg.sv @@
package coe_hvp_pkg;

    // Longest token kept, in hex digits
    localparam int TOKEN_MAX_DIGITS_DEF = 255;

    localparam int KW_LEN  = 28;
    localparam int WIN_LEN = KW_LEN - 1;
    localparam logic [8*KW_LEN-1:0] KEYWORD_STR = {"memory_", "initialization_", "vector"};

    // Final status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ODD_TOKEN  = 2'd1;
    localparam logic [1:0] ST_NO_DATA    = 2'd2;
    localparam logic [1:0] ST_KW_MISSING = 2'd3;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  out_byte;
        logic [1:0]  status_code;
        logic [31:0] byte_total;
        logic        last_result;
    } result_t;

    // Keyword character i, counted from the first character
    function automatic logic [7:0] kw_char(input int i);
        kw_char = KEYWORD_STR[8*(KW_LEN-1-i) +: 8];
    endfunction

    // Lower-case fold for A..Z
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        fold_char = (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
              || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
        end
        hex_val = t[3:0];
    endfunction

endpackage

@@ hdl/coe_hex_vector_parser.sv @@
// Each result is written into the registered result queue and presented on m_* from there.
// Throughput: one character per cycle; the input stalls only when the 4-entry
// result queue has fewer than two free slots (an end_of_file character can
// push a data byte and the status in the same cycle).
// Reset (aresetn low, synchronous): raw_mode = 0, parser back to keyword
// search, result queue emptied; queue payload is not cleared.
module coe_hex_vector_parser #(
    parameter int TOKEN_MAX_DIGITS = coe_hvp_pkg::TOKEN_MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // character stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_char,
    input  logic        s_end_of_file,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_status_code,
    output logic [31:0] m_byte_total,
    output logic        m_last_result
);

    localparam int DC_W    = $clog2(TOKEN_MAX_DIGITS + 1);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_PARSE,
        PH_DONE,
        PH_NOKW
    } phase_t;

    // ---------------- parser state ----------------
    phase_t         phase_reg, phase_next;
    logic [7:0]     window_reg [coe_hvp_pkg::WIN_LEN];   // folded, oldest first
    logic [7:0]     window_next [coe_hvp_pkg::WIN_LEN];
    logic [DC_W-1:0] dc_reg, dc_next;
    logic [3:0]     nibble_reg, nibble_next;
    logic [31:0]    bytes_reg, bytes_next;
    logic           err_reg, err_next;
    logic           open_reg, open_next;
    logic           raw_reg;

    // ---------------- result queue ----------------
    coe_hvp_pkg::result_t q_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] q_cnt_reg;

    logic                 accept, pop;
    logic                 push_data, push_stat;
    coe_hvp_pkg::result_t data_res, stat_res;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = (q_cnt_reg <= Q_CW'(Q_DEPTH - 2));
    assign m_valid = (q_cnt_reg != '0);

    // Per-character step: all of it is one pass of combinational logic
    always_comb begin
        logic [7:0] fc;
        logic       match;
        logic       hex;
        logic [1:0] code;
        fc          = coe_hvp_pkg::fold_char(s_in_char);
        hex         = coe_hvp_pkg::is_hex(s_in_char);
        match       = (fc == coe_hvp_pkg::kw_char(coe_hvp_pkg::KW_LEN - 1));
        code        = coe_hvp_pkg::ST_OK;
        phase_next  = phase_reg;
        window_next = window_reg;
        dc_next     = dc_reg;
        nibble_next = nibble_reg;
        bytes_next  = bytes_reg;
        err_next    = err_reg;
        open_next   = open_reg;
        push_data   = 1'b0;
        push_stat   = 1'b0;
        data_res    = '0;
        stat_res    = '0;

        for (int i = 0; i < coe_hvp_pkg::WIN_LEN; i++) begin
            if (window_reg[i] != coe_hvp_pkg::kw_char(i)) begin
                match = 1'b0;
            end
        end

        if (accept) begin
            open_next = 1'b1;
            case (phase_reg)
                PH_SEARCH: begin
                    if (s_in_char == 8'h00) begin
                        phase_next = PH_NOKW;
                    end else begin
                        for (int i = 0; i < coe_hvp_pkg::WIN_LEN - 1; i++) begin
                            window_next[i] = window_reg[i+1];
                        end
                        window_next[coe_hvp_pkg::WIN_LEN-1] = fc;
                        if (match) begin
                            phase_next = PH_PARSE;
                        end
                    end
                end
                PH_PARSE: begin
                    if (s_in_char == 8'h00 || !hex) begin
                        // token ends here
                        if (dc_reg[0]) begin
                            err_next = 1'b1;
                        end
                        if (dc_reg[0] || s_in_char == 8'h00) begin
                            phase_next = PH_DONE;
                        end
                        dc_next = '0;
                    end else if (dc_reg < DC_W'(TOKEN_MAX_DIGITS)) begin
                        dc_next = dc_reg + 1'b1;
                        if (!dc_reg[0]) begin
                            nibble_next = coe_hvp_pkg::hex_val(s_in_char);
                        end else begin
                            push_data          = 1'b1;
                            data_res.out_byte  = {nibble_reg, coe_hvp_pkg::hex_val(s_in_char)};
                            if (bytes_reg != 32'hffff_ffff) begin
                                bytes_next = bytes_reg + 32'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (s_end_of_file) begin
                // pending token of a file cut off mid-parse
                if (phase_next == PH_PARSE && dc_next[0]) begin
                    err_next = 1'b1;
                end
                if (err_next) begin
                    code = coe_hvp_pkg::ST_ODD_TOKEN;
                end else if (phase_next == PH_SEARCH || phase_next == PH_NOKW) begin
                    code = coe_hvp_pkg::ST_KW_MISSING;
                end else if (bytes_next == 32'd0) begin
                    code = coe_hvp_pkg::ST_NO_DATA;
                end
                push_stat            = 1'b1;
                stat_res.is_status   = 1'b1;
                stat_res.status_code = code;
                stat_res.byte_total  = bytes_next;
                stat_res.last_result = 1'b1;
                // re-arm for the next file
                phase_next = raw_reg ? PH_PARSE : PH_SEARCH;
                for (int i = 0; i < coe_hvp_pkg::WIN_LEN; i++) begin
                    window_next[i] = 8'h00;
                end
                dc_next     = '0;
                nibble_next = 4'h0;
                bytes_next  = 32'd0;
                err_next    = 1'b0;
                open_next   = 1'b0;
            end
        end

        // mode applies at once only between files
        if (cfg_we && !open_reg) begin
            phase_next = cfg_wdata ? PH_PARSE : PH_SEARCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEARCH;
            for (int i = 0; i < coe_hvp_pkg::WIN_LEN; i++) begin
                window_reg[i] <= 8'h00;
            end
            dc_reg     <= '0;
            nibble_reg <= 4'h0;
            bytes_reg  <= 32'd0;
            err_reg    <= 1'b0;
            open_reg   <= 1'b0;
            raw_reg    <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            dc_reg     <= dc_next;
            nibble_reg <= nibble_next;
            bytes_reg  <= bytes_next;
            err_reg    <= err_next;
            open_reg   <= open_next;
            if (cfg_we) begin
                raw_reg <= cfg_wdata;
            end
        end
    end

    // ---------------- result queue ----------------
    always_ff @(posedge aclk) begin
        if (push_data) begin
            q_reg[wr_ptr_reg] <= data_res;
        end
        if (push_stat) begin
            q_reg[push_data ? wr_ptr_reg + 1'b1 : wr_ptr_reg] <= stat_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + Q_AW'(push_data) + Q_AW'(push_stat);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + Q_CW'(push_data) + Q_CW'(push_stat) - Q_CW'(pop);
        end
    end

    assign m_is_status   = q_reg[rd_ptr_reg].is_status;
    assign m_out_byte    = q_reg[rd_ptr_reg].out_byte;
    assign m_status_code = q_reg[rd_ptr_reg].status_code;
    assign m_byte_total  = q_reg[rd_ptr_reg].byte_total;
    assign m_last_result = q_reg[rd_ptr_reg].last_result;

    // ---------------- assertions ----------------
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= Q_CW'(Q_DEPTH))
        else $error("result queue overflow");

    a_data_only_parsing: assert property (@(posedge aclk) disable iff (!aresetn)
        push_data |-> phase_reg == PH_PARSE)
        else $error("data byte outside parse phase");

    a_status_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_result == m_is_status)
                 && (m_is_status ? (m_out_byte == 8'h00)
                                 : (m_byte_total == 32'd0
                                    && m_status_code == coe_hvp_pkg::ST_OK)))
        else $error("result fields inconsistent with result kind");

    a_eof_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_file |=> !open_reg && dc_reg == '0 && bytes_reg == 32'd0)
        else $error("parser not re-armed after end of file");

endmodule

@@ bench/coe_parse_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the mode register port.
// Predicts the parser output per accepted character and compares field by field.
module coe_parse_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_char,
    input  logic        s_end_of_file,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_is_status,
    input  logic [7:0]  m_out_byte,
    input  logic [1:0]  m_status_code,
    input  logic [31:0] m_byte_total,
    input  logic        m_last_result,
    output int          fail_count,
    output int          pending,
    output int          results_checked
);

    localparam int KEEP_DIGITS = coe_hvp_pkg::TOKEN_MAX_DIGITS_DEF;
    localparam int WIN_LEN     = coe_hvp_pkg::WIN_LEN;
    localparam int KW_LEN      = coe_hvp_pkg::KW_LEN;

    typedef enum logic [1:0] {SEEK_KW, IN_DATA, FINISHED, NO_KW} scan_state_t;

    logic                 raw_sel = 1'b0;
    scan_state_t          scan = SEEK_KW;
    logic [7:0]           window [WIN_LEN];
    int unsigned          digits = 0;
    logic [3:0]           high_nib = 4'h0;
    logic [31:0]          byte_cnt = 32'h0;
    bit                   odd_seen = 1'b0;
    bit                   file_busy = 1'b0;
    coe_hvp_pkg::result_t parsed_q[$];
    int                   fails = 0;
    int                   seen = 0;

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    // bit 4 set when c is a hex digit, low nibble is its value
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        logic [7:0] d;
        d = lower(c);
        if (d >= 8'h30 && d <= 8'h39) begin
            d = d - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (d >= 8'h61 && d <= 8'h66) begin
            d = d - 8'h61 + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'h00;
    endfunction

    function automatic void rearm();
        scan = raw_sel ? IN_DATA : SEEK_KW;
        for (int i = 0; i < WIN_LEN; i++) window[i] = 8'h00;
        digits    = 0;
        high_nib  = 4'h0;
        byte_cnt  = 32'h0;
        odd_seen  = 1'b0;
        file_busy = 1'b0;
    endfunction

    function automatic void close_token();
        if (digits % 2 == 1) begin
            odd_seen = 1'b1;
            scan     = FINISHED;
        end
        digits = 0;
    endfunction

    function automatic void queue_result(input logic st, input logic [7:0] b,
                                         input logic [1:0] code, input logic [31:0] total);
        coe_hvp_pkg::result_t r;
        r.is_status   = st;
        r.out_byte    = b;
        r.status_code = code;
        r.byte_total  = total;
        r.last_result = st;
        parsed_q.push_back(r);
    endfunction

    function automatic void take_char(input logic [7:0] c, input logic eof);
        logic       hit;
        logic [4:0] dig;
        logic [1:0] code;
        file_busy = 1'b1;
        case (scan)
            SEEK_KW: begin
                if (c == 8'h00) begin
                    scan = NO_KW;
                end else begin
                    hit = (lower(c) == coe_hvp_pkg::kw_char(KW_LEN-1));
                    for (int i = 0; i < WIN_LEN; i++)
                        if (lower(window[i]) != coe_hvp_pkg::kw_char(i)) hit = 1'b0;
                    for (int i = 0; i < WIN_LEN - 1; i++) window[i] = window[i+1];
                    window[WIN_LEN-1] = c;
                    if (hit) scan = IN_DATA;
                end
            end
            IN_DATA: begin
                dig = decode_hex(c);
                if (c == 8'h00) begin
                    close_token();
                    if (scan == IN_DATA) scan = FINISHED;
                end else if (dig[4]) begin
                    if (digits < KEEP_DIGITS) begin
                        digits++;
                        if (digits % 2 == 1) begin
                            high_nib = dig[3:0];
                        end else begin
                            queue_result(1'b0, {high_nib, dig[3:0]}, coe_hvp_pkg::ST_OK,
                                         32'h0);
                            if (byte_cnt != 32'hffff_ffff) byte_cnt++;
                        end
                    end
                end else begin
                    close_token();
                end
            end
            default: ;
        endcase

        if (eof) begin
            if (scan == IN_DATA) close_token();
            if (odd_seen) code = coe_hvp_pkg::ST_ODD_TOKEN;
            else if (scan == SEEK_KW || scan == NO_KW) code = coe_hvp_pkg::ST_KW_MISSING;
            else if (byte_cnt == 32'h0) code = coe_hvp_pkg::ST_NO_DATA;
            else code = coe_hvp_pkg::ST_OK;
            queue_result(1'b1, 8'h00, code, byte_cnt);
            rearm();
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        coe_hvp_pkg::result_t want;
        if (!aresetn) begin
            raw_sel = 1'b0;
            rearm();
            parsed_q.delete();
        end else begin
            // results first: a result never leaves in the cycle its character arrives
            if (m_valid && m_ready) begin
                seen++;
                if (parsed_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %b %h %0d %0h %b",
                             $time, m_is_status, m_out_byte, m_status_code,
                             m_byte_total, m_last_result);
                end else begin
                    want = parsed_q.pop_front();
                    check_field("is_status", 32'(want.is_status), 32'(m_is_status));
                    check_field("out_byte", 32'(want.out_byte), 32'(m_out_byte));
                    check_field("status_code", 32'(want.status_code), 32'(m_status_code));
                    check_field("byte_total", want.byte_total, m_byte_total);
                    check_field("last_result", 32'(want.last_result), 32'(m_last_result));
                end
            end
            // mode change is deferred while a file is open
            if (cfg_we) begin
                raw_sel = cfg_wdata;
                if (!file_busy) scan = raw_sel ? IN_DATA : SEEK_KW;
            end
            if (s_valid && s_ready) take_char(s_in_char, s_end_of_file);
        end
        fail_count      <= fails;
        pending         <= parsed_q.size();
        results_checked <= seen;
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the COE hex parser.
// Checking lives in coe_parse_checker, which sits beside the DUT on the same wires.
module testbench;

    localparam int CHAR_TARGET  = 1950; // random part length, in characters
    localparam int DRAIN_CYCLES = 6;    // settle margin after the last predicted result
    localparam int KW_LEN       = coe_hvp_pkg::KW_LEN;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_char = 8'h00;
    logic        s_end_of_file = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_is_status;
    logic [7:0]  m_out_byte;
    logic [1:0]  m_status_code;
    logic [31:0] m_byte_total;
    logic        m_last_result;

    int          fail_count;
    int          pending;
    int          results_checked;

    // sender bookkeeping
    int          burst_left = 0;
    int          chars_sent = 0;
    int          files_sent = 0;
    int          mode_writes = 0;
    int unsigned rx_cycle = 0;
    logic [7:0]  text_q[$];   // file being assembled, one byte per transaction

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    coe_hex_vector_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_end_of_file (s_end_of_file),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_status   (m_is_status),
        .m_out_byte    (m_out_byte),
        .m_status_code (m_status_code),
        .m_byte_total  (m_byte_total),
        .m_last_result (m_last_result)
    );

    coe_parse_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_char       (s_in_char),
        .s_end_of_file   (s_end_of_file),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_status     (m_is_status),
        .m_out_byte      (m_out_byte),
        .m_status_code   (m_status_code),
        .m_byte_total    (m_byte_total),
        .m_last_result   (m_last_result),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Receiver: cycles through four back-pressure styles, chosen by rx_cycle[9:8].
    //   0 always ready, 1 coin flip, 2 ready while rx_cycle[4:0] is below 20, 3 ready when rx_cycle[1:0] is 0.
    // Style 2 fills the DUT result queue and forces s_ready low.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_ready <= (rx_cycle[4:0] < 5'd20);
            default: m_ready <= (rx_cycle[1:0] == 2'b00);
        endcase
    end

    function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(lo, hi);
        return r[7:0];
    endfunction

    function automatic void add_char(input logic [7:0] c);
        text_q.push_back(c);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endfunction

    // keyword with random letter case; the match is case-insensitive
    function automatic void add_keyword(input int count);
        logic [7:0] c;
        for (int i = 0; i < count; i++) begin
            c = coe_hvp_pkg::kw_char(i);
            if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) c = c & 8'hdf;
            add_char(c);
        end
    endfunction

    // keyword mode needs the keyword before any data
    function automatic void add_header(input logic raw);
        if (!raw) begin
            add_keyword(KW_LEN);
            add_char("=");
        end
    endfunction

    // n hex digits, mixed case
    function automatic void add_digits(input int n);
        int unsigned v;
        for (int i = 0; i < n; i++) begin
            v = $urandom_range(0, 21);
            if (v < 10) add_char(8'h30 + v[7:0]);
            else if (v < 16) add_char(8'h61 + v[7:0] - 8'd10);
            else add_char(8'h41 + v[7:0] - 8'd16);
        end
    endfunction

    // any non-hex, non-NUL character ends a token
    function automatic void add_sep();
        case ($urandom_range(0, 7))
            0:       add_char(8'h20);
            1:       add_char(",");
            2:       add_char(8'h0a);
            3:       add_char(";");
            4:       add_char(8'h0d);
            5:       add_char(8'h09);
            6:       add_char(rand_byte(8'h67, 8'h7a));   // g..z
            default: add_char(rand_byte(8'h80, 8'hff));
        endcase
    endfunction

    function automatic void add_noise(input int n);
        for (int i = 0; i < n; i++) add_char(rand_byte(0, 255));
    endfunction

    // One random file. Mostly well-formed text with random content, some broken
    // files (keyword cut short, odd token, NUL in the data, no data) and some noise.
    function automatic void build_file(input logic raw, input int file_no);
        int kind;
        int ntok;
        kind = $urandom_range(0, 99);
        if (file_no % 29 == 7) begin
            // long token: 254 digits are kept whole, 256 get cut to an odd 255
            add_header(raw);
            add_digits((file_no % 2 == 1) ? 254 : 256);
            add_sep();
        end else if (kind < 70) begin
            if (!raw) begin
                if ($urandom_range(0, 3) == 0) add_text("memory_initialization_radix=16;\n");
                else if ($urandom_range(0, 1) == 1) add_sep();
            end
            add_header(raw);
            ntok = $urandom_range(1, 8);
            for (int i = 0; i < ntok; i++) begin
                add_digits(2 * $urandom_range(1, 4));
                // last token sometimes closed by end of file itself
                if (i < ntok - 1 || $urandom_range(0, 1) == 1) add_sep();
            end
        end else if (kind < 85) begin
            case ($urandom_range(0, 3))
                0: begin
                    add_keyword($urandom_range(1, KW_LEN - 1));
                    add_char("=");
                    add_digits(4);
                end
                1: begin
                    add_header(raw);
                    add_digits(2);
                    add_sep();
                    add_digits(2 * $urandom_range(0, 3) + 1);
                    add_sep();
                    add_digits(2);
                end
                2: begin
                    add_header(raw);
                    add_digits(2 * $urandom_range(1, 3));
                    if ($urandom_range(0, 1) == 1) add_digits(1);
                    add_char(8'h00);
                    add_noise($urandom_range(0, 6));
                end
                default: begin
                    add_header(raw);
                    repeat ($urandom_range(0, 3)) add_sep();
                end
            endcase
        end else begin
            add_noise($urandom_range(1, 24));
        end
        if (text_q.size() == 0) add_sep();
    endfunction

    // One character transaction. Valid drops only at the end of a burst, and
    // a gap with valid low follows it before the next burst.
    task automatic push_char(input logic [7:0] c, input logic eof);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64)
                                                     : $urandom_range(1, 8);
        end
        s_valid       <= 1'b1;
        s_in_char     <= c;
        s_end_of_file <= eof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        burst_left--;
        if (burst_left == 0) s_valid <= 1'b0;
    endtask

    // sends the assembled text; close marks the last byte as end of file
    task automatic send_text(input bit close);
        for (int i = 0; i < text_q.size(); i++)
            push_char(text_q[i], close && (i == text_q.size() - 1));
        text_q.delete();
        if (close) files_sent++;
    endtask

    // Wait until every predicted result has been seen, then a few more cycles
    // so a character with no result is out of the pipe too.
    task automatic settle();
        // valid is already low when the burst ran out
        if (burst_left != 0) s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic raw);
        cfg_we    <= 1'b1;
        cfg_wdata <= raw;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_writes++;
    endtask

    initial begin
        int   base;
        int   files;
        logic raw;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed ----
        // keyword mode out of reset
        add_text("x");
        send_text(1'b1);                 // keyword never seen
        add_char(8'h00);
        send_text(1'b1);                 // NUL while searching
        settle();
        write_mode(1'b1);
        add_text("fF 00,");
        send_text(1'b1);                 // byte extremes, both cases
        add_text("9a7");
        send_text(1'b1);                 // odd token closed by end of file
        add_char(8'hff);
        send_text(1'b1);                 // no data at all
        add_text("ab");
        add_char(8'h00);
        add_text("1");
        send_text(1'b1);                 // NUL ends the text, trailing digit ignored
        add_text("3");
        send_text(1'b1);                 // lone digit, no byte
        // mode write while a file is open: takes effect from the next file
        add_text("c");
        send_text(1'b0);
        settle();
        write_mode(1'b0);
        add_text("d");
        send_text(1'b1);                 // still raw: byte cd
        add_text("q");
        send_text(1'b1);                 // now keyword mode: keyword missing

        // ---- random phases, mode picked per phase ----
        base = chars_sent;
        while (chars_sent - base < CHAR_TARGET) begin
            settle();
            raw = ($urandom_range(0, 1) == 1);
            write_mode(raw);
            files = $urandom_range(2, 6);
            for (int i = 0; i < files; i++) begin
                build_file(raw, files_sent);
                send_text(1'b1);
            end
        end
        settle();

        $display("Sent %0d characters in %0d files with %0d mode writes; %0d results checked.",
                 chars_sent, files_sent, mode_writes, results_checked);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/coe_hvp_pkg.sv
hdl/coe_hex_vector_parser.sv
bench/coe_parse_checker.sv
bench/testbench.sv
